// ----- rtl/ptq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared sizes, codes and types of the periodic timer queue.
// ----------------------------------------------------------------------------
package ptq_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int MAX_RESULTS = 16;

    localparam int SLOT_W  = $clog2(TIMER_SLOTS);
    localparam int CNT_W   = $clog2(TIMER_SLOTS + 1);
    localparam int RES_W   = $clog2(MAX_RESULTS + 1);
    localparam int ORD_W   = $clog2(MAX_RESULTS);
    localparam int TIME_W  = 48;
    localparam int IVAL_W  = 32;
    localparam int SEQ_W   = 32;
    localparam int FSLOT_W = 4;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_CANCEL = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_EXPIRED   = 3'd4;
    localparam logic [2:0] ST_NONE      = 3'd5;

    // Running minimum handed from cell to cell
    typedef struct packed {
        logic              any;
        logic [TIME_W-1:0] exp;
        logic [SLOT_W-1:0] idx;
        logic [SEQ_W-1:0]  seq;
    } t_link;

    typedef struct packed {
        logic wr;
        logic clr;
        logic take;
        logic rearm;
        logic untake;
    } t_cell_cmd;

endpackage

// ----- rtl/ptq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptq_cell
// One timer slot: holds its timer and folds itself into the running minimum.
// ----------------------------------------------------------------------------
module ptq_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ptq_pkg::SLOT_W-1:0] i_idx,
    input  ptq_pkg::t_cell_cmd         i_cmd,
    input  logic [ptq_pkg::TIME_W-1:0] i_time,
    input  logic [ptq_pkg::IVAL_W-1:0] i_ival,
    input  logic [ptq_pkg::SEQ_W-1:0]  i_seq,
    input  logic                       i_pick,
    input  logic [ptq_pkg::TIME_W-1:0] i_now,
    input  ptq_pkg::t_link             i_link,
    output ptq_pkg::t_link             o_link,
    output logic                       o_valid,
    output logic [ptq_pkg::SEQ_W-1:0]  o_seq
);

    logic                       r_valid;
    logic                       r_taken;
    logic [ptq_pkg::TIME_W-1:0] r_exp;
    logic [ptq_pkg::IVAL_W-1:0] r_ival;
    logic [ptq_pkg::SEQ_W-1:0]  r_seq;
    ptq_pkg::t_link             r_link;
    ptq_pkg::t_link             n_link;
    logic [ptq_pkg::TIME_W:0]   w_sum;
    logic [ptq_pkg::TIME_W-1:0] w_rearm;
    logic                       w_elig;

    assign w_sum   = {1'b0, i_now} + {{(ptq_pkg::TIME_W + 1 - ptq_pkg::IVAL_W){1'b0}}, r_ival};
    // saturate at the top of the time range
    assign w_rearm = w_sum[ptq_pkg::TIME_W] ? {ptq_pkg::TIME_W{1'b1}}
                                            : w_sum[ptq_pkg::TIME_W-1:0];
    assign w_elig  = r_valid && (!i_pick || (!r_taken && (r_exp <= i_now)));

    always_comb begin
        n_link = i_link;
        // strict compare keeps the lower slot on a tie
        if (w_elig && (!i_link.any || (r_exp < i_link.exp))) begin
            n_link.any = 1'b1;
            n_link.exp = r_exp;
            n_link.idx = i_idx;
            n_link.seq = r_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_taken <= 1'b0;
            r_link  <= '0;
        end else begin
            r_link <= n_link;
            if (i_cmd.wr) begin
                r_valid <= 1'b1;
            end else if (i_cmd.clr) begin
                r_valid <= 1'b0;
            end else if (i_cmd.rearm && r_taken && (r_ival == '0)) begin
                r_valid <= 1'b0;
            end
            if (i_cmd.take) begin
                r_taken <= 1'b1;
            end else if (i_cmd.untake) begin
                r_taken <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_exp  <= i_time;
            r_ival <= i_ival;
            r_seq  <= i_seq;
        end else if (i_cmd.rearm && r_taken && (r_ival != '0)) begin
            r_exp <= w_rearm;
        end
    end

    assign o_link  = r_link;
    assign o_valid = r_valid;
    assign o_seq   = r_seq;

endmodule

// ----- rtl/periodic_timer_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_queue
// Table of armed timers with add, cancel and tick; emits expired timers in
// expiry order and reports the next expiry.
// ----------------------------------------------------------------------------
// Channel  Dir  tuser        tdata                                  tlast
// s_axis   in   func         time_us, interval_us, cancel_slot, seq -
// m_axis   out  status       slot, seq, earliest_changed, next, nv  last
//
// Add: result ready the cycle after the transfer.
// Cancel: one pass of the cell chain.
// Tick: a chain pass per expired timer (at most MAX_RESULTS), one more pass
// and a final pass, then one result per cycle while m_axis takes them.
// Synchronous reset empties the table; one item is worked at a time and
// s_axis_tready stays low until its last result has been loaded out.
// ----------------------------------------------------------------------------
module periodic_timer_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [1:0]   s_axis_tuser,   // func
    input  logic [119:0] s_axis_tdata,   // time_us, interval_us, cancel_slot, cancel_seq
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [2:0]   m_axis_tuser,   // status
    output logic [87:0]  m_axis_tdata,   // slot, seq, earliest_changed, next_expiry_us, next_valid
    output logic         m_axis_tlast
);

    localparam int N = ptq_pkg::TIMER_SLOTS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam logic [1:0] PH_CANCEL = 2'd0;
    localparam logic [1:0] PH_PICK   = 2'd1;
    localparam logic [1:0] PH_FINAL  = 2'd2;

    logic [ptq_pkg::TIME_W-1:0]  w_time;
    logic [ptq_pkg::IVAL_W-1:0]  w_ival;
    logic [ptq_pkg::FSLOT_W-1:0] w_cs;
    logic [ptq_pkg::SEQ_W-1:0]   w_cq;

    assign w_time = s_axis_tdata[47:0];
    assign w_ival = s_axis_tdata[79:48];
    assign w_cs   = s_axis_tdata[83:80];
    assign w_cq   = s_axis_tdata[115:84];

    logic [1:0]                  r_state, n_state;
    logic [1:0]                  r_phase, n_phase;
    logic [ptq_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [ptq_pkg::RES_W-1:0]   r_n, n_n;
    logic [ptq_pkg::RES_W-1:0]   r_k, n_k;
    logic                        r_pick, n_pick;
    logic [ptq_pkg::TIME_W-1:0]  r_now, n_now;
    logic [ptq_pkg::FSLOT_W-1:0] r_cs, n_cs;
    logic [ptq_pkg::SEQ_W-1:0]   r_cq, n_cq;
    logic                        r_hit, n_hit;
    logic [ptq_pkg::TIME_W-1:0]  r_ne, n_ne;
    logic                        r_nv, n_nv;
    logic [ptq_pkg::SEQ_W-1:0]   r_seqc, n_seqc;
    logic                        r_ovalid, n_ovalid;
    logic [2:0]                  r_o_status, n_o_status;
    logic [ptq_pkg::FSLOT_W-1:0] r_o_slot, n_o_slot;
    logic [ptq_pkg::SEQ_W-1:0]   r_o_seq, n_o_seq;
    logic                        r_o_chg, n_o_chg;
    logic                        r_o_last, n_o_last;

    logic [ptq_pkg::SLOT_W-1:0]  r_ord_slot [ptq_pkg::MAX_RESULTS];
    logic [ptq_pkg::SEQ_W-1:0]   r_ord_seq  [ptq_pkg::MAX_RESULTS];

    ptq_pkg::t_link              w_link [N+1];
    ptq_pkg::t_cell_cmd          w_cmd  [N];
    logic [N-1:0]                w_valid;
    logic [ptq_pkg::SEQ_W-1:0]   w_seq  [N];
    logic [ptq_pkg::SEQ_W-1:0]   w_new_seq;
    logic                        w_free_any;
    logic [ptq_pkg::SLOT_W-1:0]  w_free_idx;
    logic                        w_hit;
    logic                        w_chg;
    logic                        c_wr, c_clr, c_take, c_rearm, c_untake;
    ptq_pkg::t_link              w_end;

    assign w_link[0] = '0;
    assign w_end     = w_link[N];
    assign w_new_seq = r_seqc + ptq_pkg::SEQ_W'(1);
    assign w_free_any = ~&w_valid;
    assign w_chg     = !r_nv || (w_time < r_ne);

    always_comb begin
        w_free_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!w_valid[i]) begin
                w_free_idx = ptq_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb begin
        w_hit = 1'b0;
        for (int i = 0; i < N; i++) begin
            if (w_valid[i] && (w_seq[i] == w_cq) && (32'(w_cs) == i)) begin
                w_hit = 1'b1;
            end
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        assign w_cmd[g].wr     = c_wr && (w_free_idx == ptq_pkg::SLOT_W'(g));
        assign w_cmd[g].clr    = c_clr && (32'(w_cs) == g);
        assign w_cmd[g].take   = c_take && (w_end.idx == ptq_pkg::SLOT_W'(g));
        assign w_cmd[g].rearm  = c_rearm;
        assign w_cmd[g].untake = c_untake;

        ptq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (ptq_pkg::SLOT_W'(g)),
            .i_cmd   (w_cmd[g]),
            .i_time  (w_time),
            .i_ival  (w_ival),
            .i_seq   (w_new_seq),
            .i_pick  (r_pick),
            .i_now   (r_now),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1]),
            .o_valid (w_valid[g]),
            .o_seq   (w_seq[g])
        );
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_n        = r_n;
        n_k        = r_k;
        n_pick     = r_pick;
        n_now      = r_now;
        n_cs       = r_cs;
        n_cq       = r_cq;
        n_hit      = r_hit;
        n_ne       = r_ne;
        n_nv       = r_nv;
        n_seqc     = r_seqc;
        n_ovalid   = r_ovalid;
        n_o_status = r_o_status;
        n_o_slot   = r_o_slot;
        n_o_seq    = r_o_seq;
        n_o_chg    = r_o_chg;
        n_o_last   = r_o_last;
        c_wr       = 1'b0;
        c_clr      = 1'b0;
        c_take     = 1'b0;
        c_rearm    = 1'b0;
        c_untake   = 1'b0;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    unique case (s_axis_tuser)
                        ptq_pkg::FUNC_ADD: begin
                            n_ovalid = 1'b1;
                            n_o_last = 1'b1;
                            if (w_free_any) begin
                                c_wr       = 1'b1;
                                n_seqc     = w_new_seq;
                                n_ne       = w_chg ? w_time : r_ne;
                                n_nv       = 1'b1;
                                n_o_status = ptq_pkg::ST_ADDED;
                                n_o_slot   = ptq_pkg::FSLOT_W'(w_free_idx);
                                n_o_seq    = w_new_seq;
                                n_o_chg    = w_chg;
                            end else begin
                                n_o_status = ptq_pkg::ST_FULL;
                                n_o_slot   = '0;
                                n_o_seq    = '0;
                                n_o_chg    = 1'b0;
                            end
                        end
                        ptq_pkg::FUNC_CANCEL: begin
                            c_clr   = w_hit;
                            n_hit   = w_hit;
                            n_cs    = w_cs;
                            n_cq    = w_cq;
                            n_pick  = 1'b0;
                            n_phase = PH_CANCEL;
                            n_cnt   = ptq_pkg::CNT_W'(N);
                            n_state = S_SCAN;
                        end
                        ptq_pkg::FUNC_TICK: begin
                            n_now   = w_time;
                            n_pick  = 1'b1;
                            n_n     = '0;
                            n_phase = PH_PICK;
                            n_cnt   = ptq_pkg::CNT_W'(N);
                            n_state = S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_cnt != '0) begin
                    n_cnt = r_cnt - ptq_pkg::CNT_W'(1);
                end else begin
                    unique case (r_phase)
                        PH_CANCEL: begin
                            n_ne       = w_end.any ? w_end.exp : '0;
                            n_nv       = w_end.any;
                            n_ovalid   = 1'b1;
                            n_o_status = r_hit ? ptq_pkg::ST_CANCELLED
                                               : ptq_pkg::ST_NOT_FOUND;
                            n_o_slot   = r_cs;
                            n_o_seq    = r_cq;
                            n_o_chg    = 1'b0;
                            n_o_last   = 1'b1;
                            n_state    = S_IDLE;
                        end
                        PH_PICK: begin
                            if (w_end.any && (r_n < ptq_pkg::RES_W'(ptq_pkg::MAX_RESULTS))) begin
                                c_take = 1'b1;
                                n_n    = r_n + ptq_pkg::RES_W'(1);
                                n_cnt  = ptq_pkg::CNT_W'(N);
                            end else if (r_n == '0) begin
                                n_ovalid   = 1'b1;
                                n_o_status = ptq_pkg::ST_NONE;
                                n_o_slot   = '0;
                                n_o_seq    = '0;
                                n_o_chg    = 1'b0;
                                n_o_last   = 1'b1;
                                n_state    = S_IDLE;
                            end else begin
                                // re-arm or free every picked timer, then rescan
                                c_rearm = 1'b1;
                                n_pick  = 1'b0;
                                n_phase = PH_FINAL;
                                n_cnt   = ptq_pkg::CNT_W'(N);
                            end
                        end
                        PH_FINAL: begin
                            c_untake = 1'b1;
                            n_ne     = w_end.any ? w_end.exp : '0;
                            n_nv     = w_end.any;
                            n_k      = '0;
                            n_state  = S_EMIT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid   = 1'b1;
                    n_o_status = ptq_pkg::ST_EXPIRED;
                    n_o_slot   = ptq_pkg::FSLOT_W'(r_ord_slot[r_k[ptq_pkg::ORD_W-1:0]]);
                    n_o_seq    = r_ord_seq[r_k[ptq_pkg::ORD_W-1:0]];
                    n_o_chg    = 1'b0;
                    n_o_last   = (r_k + ptq_pkg::RES_W'(1)) == r_n;
                    n_k        = r_k + ptq_pkg::RES_W'(1);
                    if ((r_k + ptq_pkg::RES_W'(1)) == r_n) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_CANCEL;
            r_cnt    <= '0;
            r_n      <= '0;
            r_k      <= '0;
            r_pick   <= 1'b0;
            r_ne     <= '0;
            r_nv     <= 1'b0;
            r_seqc   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_n      <= n_n;
            r_k      <= n_k;
            r_pick   <= n_pick;
            r_ne     <= n_ne;
            r_nv     <= n_nv;
            r_seqc   <= n_seqc;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now      <= n_now;
        r_cs       <= n_cs;
        r_cq       <= n_cq;
        r_hit      <= n_hit;
        r_o_status <= n_o_status;
        r_o_slot   <= n_o_slot;
        r_o_seq    <= n_o_seq;
        r_o_chg    <= n_o_chg;
        r_o_last   <= n_o_last;
        if (c_take) begin
            r_ord_slot[r_n[ptq_pkg::ORD_W-1:0]] <= w_end.idx;
            r_ord_seq[r_n[ptq_pkg::ORD_W-1:0]]  <= w_end.seq;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {2'b00, r_nv, r_ne, r_o_chg, r_o_seq, r_o_slot};

endmodule
